/* hdl/xmm_register_type_tracker_macros.svh */
`ifndef XMM_REGISTER_TYPE_TRACKER_MACROS_SVH
`define XMM_REGISTER_TYPE_TRACKER_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define XRTT_CHK_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("xmm register type tracker check failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define XRTT_CHK_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("xmm register type tracker check failed");

`endif

/* hdl/xrtt_pkg.sv */
package xrtt_pkg;

	localparam logic [1:0] TY_UNK = 2'd0;
	localparam logic [1:0] TY_FLT = 2'd1;
	localparam logic [1:0] TY_DBL = 2'd2;
	localparam logic [1:0] TY_INT = 2'd3;

	localparam logic [3:0] SZ_NONE = 4'd0;
	localparam logic [3:0] SZ_B = 4'd1;
	localparam logic [3:0] SZ_W = 4'd2;
	localparam logic [3:0] SZ_D = 4'd4;
	localparam logic [3:0] SZ_Q = 4'd8;

	localparam logic [1:0] REP_F2 = 2'd2;
	localparam logic [1:0] REP_F3 = 2'd3;

	localparam logic [8:0] OP_MOVUPS_LD = 9'h110;
	localparam logic [8:0] OP_MOVUPS_ST = 9'h111;
	localparam logic [8:0] OP_MOVAPS_LD = 9'h128;
	localparam logic [8:0] OP_MOVAPS_ST = 9'h129;
	localparam logic [8:0] OP_CVTI2F = 9'h12A;
	localparam logic [8:0] OP_UCOMIS = 9'h12E;
	localparam logic [8:0] OP_COMIS = 9'h12F;
	localparam logic [8:0] OP_SQRT = 9'h151;
	localparam logic [8:0] OP_RSQRT = 9'h152;
	localparam logic [8:0] OP_RCP = 9'h153;
	localparam logic [8:0] OP_ADD = 9'h158;
	localparam logic [8:0] OP_MUL = 9'h159;
	localparam logic [8:0] OP_CVTF2F = 9'h15A;
	localparam logic [8:0] OP_CVTDQ = 9'h15B;
	localparam logic [8:0] OP_SUB = 9'h15C;
	localparam logic [8:0] OP_MIN = 9'h15D;
	localparam logic [8:0] OP_DIV = 9'h15E;
	localparam logic [8:0] OP_MAX = 9'h15F;
	localparam logic [8:0] OP_PACKSSWB = 9'h163;
	localparam logic [8:0] OP_PCMPGTB = 9'h164;
	localparam logic [8:0] OP_PCMPGTW = 9'h165;
	localparam logic [8:0] OP_PCMPGTD = 9'h166;
	localparam logic [8:0] OP_PACKUSWB = 9'h167;
	localparam logic [8:0] OP_PACKSSDW = 9'h16B;
	localparam logic [8:0] OP_MOVDQA = 9'h16F;
	localparam logic [8:0] OP_PSHIFTW = 9'h171;
	localparam logic [8:0] OP_PSHIFTD = 9'h172;
	localparam logic [8:0] OP_PSHIFTQ = 9'h173;
	localparam logic [8:0] OP_PCMPEQB = 9'h174;
	localparam logic [8:0] OP_PCMPEQW = 9'h175;
	localparam logic [8:0] OP_PCMPEQD = 9'h176;
	localparam logic [8:0] OP_HADD = 9'h17C;
	localparam logic [8:0] OP_HSUB = 9'h17D;
	localparam logic [8:0] OP_CMP = 9'h1C2;
	localparam logic [8:0] OP_ADDSUB = 9'h1D0;
	localparam logic [8:0] OP_PSRLW = 9'h1D1;
	localparam logic [8:0] OP_PSRLD = 9'h1D2;
	localparam logic [8:0] OP_PSRLQ = 9'h1D3;
	localparam logic [8:0] OP_PADDQ = 9'h1D4;
	localparam logic [8:0] OP_PMULLW = 9'h1D5;
	localparam logic [8:0] OP_PSUBUSB = 9'h1D8;
	localparam logic [8:0] OP_PSUBUSW = 9'h1D9;
	localparam logic [8:0] OP_PMINUB = 9'h1DA;
	localparam logic [8:0] OP_PADDUSB = 9'h1DC;
	localparam logic [8:0] OP_PADDUSW = 9'h1DD;
	localparam logic [8:0] OP_PMAXUB = 9'h1DE;
	localparam logic [8:0] OP_PAVGB = 9'h1E0;
	localparam logic [8:0] OP_PSRAW = 9'h1E1;
	localparam logic [8:0] OP_PSRAD = 9'h1E2;
	localparam logic [8:0] OP_PAVGW = 9'h1E3;
	localparam logic [8:0] OP_PMULHUW = 9'h1E4;
	localparam logic [8:0] OP_PMULHW = 9'h1E5;
	localparam logic [8:0] OP_PSUBSB = 9'h1E8;
	localparam logic [8:0] OP_PSUBSW = 9'h1E9;
	localparam logic [8:0] OP_PMINSW = 9'h1EA;
	localparam logic [8:0] OP_PADDSB = 9'h1EC;
	localparam logic [8:0] OP_PADDSW = 9'h1ED;
	localparam logic [8:0] OP_PMAXSW = 9'h1EE;
	localparam logic [8:0] OP_PSLLW = 9'h1F1;
	localparam logic [8:0] OP_PSLLD = 9'h1F2;
	localparam logic [8:0] OP_PSLLQ = 9'h1F3;
	localparam logic [8:0] OP_PMULUDQ = 9'h1F4;
	localparam logic [8:0] OP_PMADDWD = 9'h1F5;
	localparam logic [8:0] OP_PSADBW = 9'h1F6;
	localparam logic [8:0] OP_PSUBB = 9'h1F8;
	localparam logic [8:0] OP_PSUBW = 9'h1F9;
	localparam logic [8:0] OP_PSUBD = 9'h1FA;
	localparam logic [8:0] OP_PSUBQ = 9'h1FB;
	localparam logic [8:0] OP_PADDB = 9'h1FC;
	localparam logic [8:0] OP_PADDW = 9'h1FD;
	localparam logic [8:0] OP_PADDD = 9'h1FE;

	typedef struct packed {
		logic       recognized;
		logic       reg_type_we;
		logic       reg_size_we;
		logic       rm_type_we;
		logic       rm_size_we;
		logic [1:0] reg_type;
		logic [3:0] reg_size;
		logic [1:0] rm_type;
		logic [3:0] rm_size;
		logic       copy_rm_to_reg;
		logic       copy_reg_to_rm;
	} xrtt_ctrl_t;

	typedef struct packed {
		logic [1:0] reg_type;
		logic [3:0] reg_size;
		logic [1:0] rm_type;
		logic [3:0] rm_size;
	} xrtt_view_t;

endpackage

/* hdl/xrtt_decode.sv */
module xrtt_decode (
	input  logic [8:0]          opcode,
	input  logic [1:0]          rep_prefix,
	input  logic                opsize_override,
	input  logic                rm_is_register,
	output xrtt_pkg::xrtt_ctrl_t ctrl
);

	logic       dbl;
	logic       rec;
	logic       types_en;
	logic       sizes_en;
	logic [1:0] t_reg;
	logic [1:0] t_rm;
	logic [3:0] s_reg;
	logic [3:0] s_rm;
	logic       cp_to_reg;
	logic       cp_to_rm;

	assign dbl = opsize_override || (rep_prefix == xrtt_pkg::REP_F2);

	always_comb begin
		rec = 1'b1;
		types_en = 1'b0;
		sizes_en = 1'b0;
		t_reg = xrtt_pkg::TY_UNK;
		t_rm = xrtt_pkg::TY_UNK;
		s_reg = xrtt_pkg::SZ_NONE;
		s_rm = xrtt_pkg::SZ_NONE;
		cp_to_reg = 1'b0;
		cp_to_rm = 1'b0;
		case (opcode)
			xrtt_pkg::OP_MOVUPS_LD, xrtt_pkg::OP_MOVUPS_ST: begin
				if (rep_prefix == xrtt_pkg::REP_F3) begin
					types_en = 1'b1;
					t_reg = xrtt_pkg::TY_FLT;
					t_rm = xrtt_pkg::TY_FLT;
				end else if (rep_prefix == xrtt_pkg::REP_F2) begin
					types_en = 1'b1;
					t_reg = xrtt_pkg::TY_DBL;
					t_rm = xrtt_pkg::TY_DBL;
				end
			end
			xrtt_pkg::OP_UCOMIS, xrtt_pkg::OP_COMIS, xrtt_pkg::OP_SQRT,
			xrtt_pkg::OP_RSQRT, xrtt_pkg::OP_RCP, xrtt_pkg::OP_ADD,
			xrtt_pkg::OP_MUL, xrtt_pkg::OP_SUB, xrtt_pkg::OP_MIN,
			xrtt_pkg::OP_DIV, xrtt_pkg::OP_MAX, xrtt_pkg::OP_CMP: begin
				types_en = 1'b1;
				t_reg = dbl ? xrtt_pkg::TY_DBL : xrtt_pkg::TY_FLT;
				t_rm = t_reg;
			end
			xrtt_pkg::OP_CVTI2F: begin
				types_en = 1'b1;
				sizes_en = 1'b1;
				s_reg = dbl ? xrtt_pkg::SZ_Q : xrtt_pkg::SZ_D;
				s_rm = xrtt_pkg::SZ_D;
				t_reg = dbl ? xrtt_pkg::TY_DBL : xrtt_pkg::TY_FLT;
				t_rm = xrtt_pkg::TY_INT;
			end
			xrtt_pkg::OP_CVTF2F: begin
				types_en = 1'b1;
				t_reg = dbl ? xrtt_pkg::TY_FLT : xrtt_pkg::TY_DBL;
				t_rm = dbl ? xrtt_pkg::TY_DBL : xrtt_pkg::TY_FLT;
			end
			xrtt_pkg::OP_CVTDQ: begin
				types_en = 1'b1;
				sizes_en = 1'b1;
				s_reg = xrtt_pkg::SZ_D;
				s_rm = xrtt_pkg::SZ_D;
				if (opsize_override || (rep_prefix == xrtt_pkg::REP_F3)) begin
					t_reg = xrtt_pkg::TY_INT;
					t_rm = xrtt_pkg::TY_FLT;
				end else begin
					t_reg = xrtt_pkg::TY_FLT;
					t_rm = xrtt_pkg::TY_INT;
				end
			end
			xrtt_pkg::OP_HADD, xrtt_pkg::OP_HSUB, xrtt_pkg::OP_ADDSUB: begin
				types_en = 1'b1;
				t_reg = opsize_override ? xrtt_pkg::TY_DBL : xrtt_pkg::TY_FLT;
				t_rm = t_reg;
			end
			xrtt_pkg::OP_PCMPGTB, xrtt_pkg::OP_PCMPEQB, xrtt_pkg::OP_PSUBUSB,
			xrtt_pkg::OP_PMINUB, xrtt_pkg::OP_PADDUSB, xrtt_pkg::OP_PMAXUB,
			xrtt_pkg::OP_PAVGB, xrtt_pkg::OP_PSUBSB, xrtt_pkg::OP_PADDSB,
			xrtt_pkg::OP_PSUBB, xrtt_pkg::OP_PADDB: begin
				types_en = 1'b1;
				sizes_en = 1'b1;
				s_reg = xrtt_pkg::SZ_B;
				s_rm = xrtt_pkg::SZ_B;
				t_reg = xrtt_pkg::TY_INT;
				t_rm = xrtt_pkg::TY_INT;
			end
			xrtt_pkg::OP_PCMPGTW, xrtt_pkg::OP_PCMPEQW, xrtt_pkg::OP_PSHIFTW,
			xrtt_pkg::OP_PSRLW, xrtt_pkg::OP_PMULLW, xrtt_pkg::OP_PSUBUSW,
			xrtt_pkg::OP_PADDUSW, xrtt_pkg::OP_PSRAW, xrtt_pkg::OP_PAVGW,
			xrtt_pkg::OP_PMULHUW, xrtt_pkg::OP_PMULHW, xrtt_pkg::OP_PSUBSW,
			xrtt_pkg::OP_PMINSW, xrtt_pkg::OP_PADDSW, xrtt_pkg::OP_PMAXSW,
			xrtt_pkg::OP_PSLLW, xrtt_pkg::OP_PSADBW, xrtt_pkg::OP_PSUBW,
			xrtt_pkg::OP_PADDW: begin
				types_en = 1'b1;
				sizes_en = 1'b1;
				s_reg = xrtt_pkg::SZ_W;
				s_rm = xrtt_pkg::SZ_W;
				t_reg = xrtt_pkg::TY_INT;
				t_rm = xrtt_pkg::TY_INT;
			end
			xrtt_pkg::OP_PCMPGTD, xrtt_pkg::OP_PCMPEQD, xrtt_pkg::OP_PSHIFTD,
			xrtt_pkg::OP_PSRLD, xrtt_pkg::OP_PSRAD, xrtt_pkg::OP_PSLLD,
			xrtt_pkg::OP_PSUBD, xrtt_pkg::OP_PADDD: begin
				types_en = 1'b1;
				sizes_en = 1'b1;
				s_reg = xrtt_pkg::SZ_D;
				s_rm = xrtt_pkg::SZ_D;
				t_reg = xrtt_pkg::TY_INT;
				t_rm = xrtt_pkg::TY_INT;
			end
			xrtt_pkg::OP_PSHIFTQ, xrtt_pkg::OP_PSRLQ, xrtt_pkg::OP_PADDQ,
			xrtt_pkg::OP_PSLLQ, xrtt_pkg::OP_PMULUDQ, xrtt_pkg::OP_PSUBQ: begin
				types_en = 1'b1;
				sizes_en = 1'b1;
				s_reg = xrtt_pkg::SZ_Q;
				s_rm = xrtt_pkg::SZ_Q;
				t_reg = xrtt_pkg::TY_INT;
				t_rm = xrtt_pkg::TY_INT;
			end
			xrtt_pkg::OP_PACKSSDW, xrtt_pkg::OP_PMADDWD: begin
				types_en = 1'b1;
				sizes_en = 1'b1;
				s_reg = xrtt_pkg::SZ_D;
				s_rm = xrtt_pkg::SZ_W;
				t_reg = xrtt_pkg::TY_INT;
				t_rm = xrtt_pkg::TY_INT;
			end
			xrtt_pkg::OP_PACKSSWB, xrtt_pkg::OP_PACKUSWB: begin
				types_en = 1'b1;
				sizes_en = 1'b1;
				s_reg = xrtt_pkg::SZ_B;
				s_rm = xrtt_pkg::SZ_W;
				t_reg = xrtt_pkg::TY_INT;
				t_rm = xrtt_pkg::TY_INT;
			end
			xrtt_pkg::OP_MOVAPS_LD: begin
				cp_to_reg = rm_is_register;
			end
			xrtt_pkg::OP_MOVAPS_ST: begin
				cp_to_rm = rm_is_register;
			end
			xrtt_pkg::OP_MOVDQA: begin
				cp_to_reg = opsize_override && rm_is_register;
			end
			default: begin
				rec = 1'b0;
			end
		endcase
	end

	always_comb begin
		ctrl.recognized = rec;
		ctrl.reg_type_we = types_en;
		ctrl.reg_size_we = sizes_en;
		ctrl.rm_type_we = types_en && rm_is_register;
		ctrl.rm_size_we = sizes_en && rm_is_register;
		ctrl.reg_type = t_reg;
		ctrl.reg_size = s_reg;
		ctrl.rm_type = t_rm;
		ctrl.rm_size = s_rm;
		ctrl.copy_rm_to_reg = cp_to_reg;
		ctrl.copy_reg_to_rm = cp_to_rm;
	end

endmodule

/* hdl/xrtt_regfile.sv */
module xrtt_regfile #(
	parameter int NUM_XMM_REGS = 16,
	localparam int IDX_W = $clog2(NUM_XMM_REGS)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 we,
	input  xrtt_pkg::xrtt_ctrl_t ctrl,
	input  logic [IDX_W-1:0]     reg_idx,
	input  logic [IDX_W-1:0]     rm_idx,
	output xrtt_pkg::xrtt_view_t view
);

	logic [1:0] type_q [NUM_XMM_REGS];
	logic [3:0] size_q [NUM_XMM_REGS];
	logic [1:0] type_nx [NUM_XMM_REGS];
	logic [3:0] size_nx [NUM_XMM_REGS];

	logic       reg_t_we;
	logic       reg_s_we;
	logic       rm_t_we;
	logic       rm_s_we;
	logic [1:0] reg_t_wd;
	logic [3:0] reg_s_wd;
	logic [1:0] rm_t_wd;
	logic [3:0] rm_s_wd;

	assign reg_t_we = ctrl.reg_type_we || ctrl.copy_rm_to_reg;
	assign reg_s_we = ctrl.reg_size_we || ctrl.copy_rm_to_reg;
	assign rm_t_we = ctrl.rm_type_we || ctrl.copy_reg_to_rm;
	assign rm_s_we = ctrl.rm_size_we || ctrl.copy_reg_to_rm;
	assign reg_t_wd = ctrl.copy_rm_to_reg ? type_q[rm_idx] : ctrl.reg_type;
	assign reg_s_wd = ctrl.copy_rm_to_reg ? size_q[rm_idx] : ctrl.reg_size;
	assign rm_t_wd = ctrl.copy_reg_to_rm ? type_q[reg_idx] : ctrl.rm_type;
	assign rm_s_wd = ctrl.copy_reg_to_rm ? size_q[reg_idx] : ctrl.rm_size;

	// rm write lands after reg write: rm wins on a shared index
	always_comb begin
		for (int i = 0; i < NUM_XMM_REGS; i++) begin
			type_nx[i] = type_q[i];
			size_nx[i] = size_q[i];
			if (reg_idx == IDX_W'(i)) begin
				if (reg_t_we) type_nx[i] = reg_t_wd;
				if (reg_s_we) size_nx[i] = reg_s_wd;
			end
			if (rm_idx == IDX_W'(i)) begin
				if (rm_t_we) type_nx[i] = rm_t_wd;
				if (rm_s_we) size_nx[i] = rm_s_wd;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_XMM_REGS; i++) begin
				type_q[i] <= xrtt_pkg::TY_UNK;
				size_q[i] <= xrtt_pkg::SZ_NONE;
			end
		end else if (we) begin
			for (int i = 0; i < NUM_XMM_REGS; i++) begin
				type_q[i] <= type_nx[i];
				size_q[i] <= size_nx[i];
			end
		end
	end

	always_comb begin
		view.reg_type = type_nx[reg_idx];
		view.reg_size = size_nx[reg_idx];
		view.rm_type = type_nx[rm_idx];
		view.rm_size = size_nx[rm_idx];
	end

endmodule

/* hdl/xmm_register_type_tracker.sv */
// A request is registered in stage 1; its result then goes to the output register.
// One request per cycle unless stalled; table update and result capture share one stage.
// A stalled result holds in the output register while one more request waits in stage 1.
// Reset: arst_n clears both stages and sets every table entry to unknown type, size zero.
module xmm_register_type_tracker #(
	parameter int NUM_XMM_REGS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [8:0] opcode,
	input  logic [1:0] rep_prefix,
	input  logic       opsize_override,
	input  logic       rm_is_register,
	input  logic [3:0] reg_index,
	input  logic [3:0] rm_index,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       recognized,
	output logic [1:0] reg_type_now,
	output logic [3:0] reg_size_now,
	output logic [1:0] rm_type_now,
	output logic [3:0] rm_size_now
);

	localparam int IDX_W = $clog2(NUM_XMM_REGS);
	localparam logic [5:0] NUM_W = 6'(NUM_XMM_REGS);

	logic             v_s1;
	logic [8:0]       op_s1;
	logic [1:0]       rep_s1;
	logic             osz_s1;
	logic             isreg_s1;
	logic [IDX_W-1:0] reg_s1;
	logic [IDX_W-1:0] rm_s1;

	logic             out_valid_q;
	logic             rec_q;
	xrtt_pkg::xrtt_view_t view_q;

	logic             in_acc;
	logic             adv;
	logic [5:0]       reg_ext;
	logic [5:0]       rm_ext;
	logic [5:0]       reg_wrap;
	logic [5:0]       rm_wrap;

	xrtt_pkg::xrtt_ctrl_t ctrl;
	xrtt_pkg::xrtt_view_t view;

	assign adv = v_s1 && (!out_valid_q || out_ready);
	assign in_ready = !v_s1 || adv;
	assign in_acc = in_valid && in_ready;

	// wrap indices into the table depth
	assign reg_ext = {2'b00, reg_index};
	assign rm_ext = {2'b00, rm_index};
	assign reg_wrap = (reg_ext >= NUM_W) ? reg_ext - NUM_W : reg_ext;
	assign rm_wrap = (rm_ext >= NUM_W) ? rm_ext - NUM_W : rm_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_s1 <= opcode;
			rep_s1 <= rep_prefix;
			osz_s1 <= opsize_override;
			isreg_s1 <= rm_is_register;
			reg_s1 <= reg_wrap[IDX_W-1:0];
			rm_s1 <= rm_wrap[IDX_W-1:0];
		end
	end

	xrtt_decode u_decode (
		.opcode          (op_s1),
		.rep_prefix      (rep_s1),
		.opsize_override (osz_s1),
		.rm_is_register  (isreg_s1),
		.ctrl            (ctrl)
	);

	xrtt_regfile #(
		.NUM_XMM_REGS (NUM_XMM_REGS)
	) u_regfile (
		.clk     (clk),
		.arst_n  (arst_n),
		.we      (adv),
		.ctrl    (ctrl),
		.reg_idx (reg_s1),
		.rm_idx  (rm_s1),
		.view    (view)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			out_valid_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rec_q <= ctrl.recognized;
			view_q <= view;
		end
	end

	assign out_valid = out_valid_q;
	assign recognized = rec_q;
	assign reg_type_now = view_q.reg_type;
	assign reg_size_now = view_q.reg_size;
	assign rm_type_now = view_q.rm_type;
	assign rm_size_now = view_q.rm_size;

endmodule

/* hdl/xrtt_checker.sv */
`include "xmm_register_type_tracker_macros.svh"

module xrtt_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic       recognized,
	input logic [1:0] reg_type_now,
	input logic [3:0] reg_size_now,
	input logic [1:0] rm_type_now,
	input logic [3:0] rm_size_now
);

	`XRTT_CHK_NXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(recognized) && $stable(reg_type_now) &&
		$stable(reg_size_now) && $stable(rm_type_now) && $stable(rm_size_now))

	`XRTT_CHK_IMP(a_block_only_on_stall, !in_ready, out_valid && !out_ready)

	`XRTT_CHK_NXT(a_full_after_stalled_accept,
		in_valid && in_ready && out_valid && !out_ready,
		in_ready == out_ready)

	`XRTT_CHK_IMP(a_int_has_size,
		out_valid && (reg_type_now == xrtt_pkg::TY_INT || rm_type_now == xrtt_pkg::TY_INT),
		(reg_type_now != xrtt_pkg::TY_INT || reg_size_now != xrtt_pkg::SZ_NONE) &&
		(rm_type_now != xrtt_pkg::TY_INT || rm_size_now != xrtt_pkg::SZ_NONE))

endmodule

bind xmm_register_type_tracker xrtt_checker u_xrtt_checker (.*);
